/* hw/rtl/pud_pkg.sv */
// Shared types, character constants and hex helpers for the percent/URL decoder.
package pud_pkg;

   localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '

   // Escape tracking between input bytes
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   // Up to three decoded bytes produced by one input transaction
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            fin;
   } run_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // Nibble value of a hex digit; zero for anything else
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         d = c - 8'h30;
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         d = c - 8'h57;
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         d = c - 8'h37;
      end
      hex_val = d[3:0];
   endfunction

endpackage

/* hw/rtl/pud_decode.sv */
// Combinational decode of one input byte against the escape state.
module pud_decode (
   input  pud_pkg::phase_type phase,
   input  logic [7:0]         held,
   input  logic [7:0]         in_char,
   input  logic               in_final,
   output pud_pkg::run_type   run,
   output pud_pkg::phase_type phase_next,
   output logic [7:0]         held_next
);
   import pud_pkg::*;

   logic       c_hex;
   logic       c_pct;
   logic [7:0] c_plain;
   logic [1:0] cnt;
   logic [7:0] b0;
   logic [7:0] b1;
   logic [7:0] b2;
   phase_type  ph;
   logic [7:0] hd;

   assign c_hex   = is_hex(in_char);
   assign c_pct   = (in_char == CHAR_PCT);
   assign c_plain = (in_char == CHAR_PLUS) ? CHAR_SPACE : in_char;

   always_comb begin
      cnt = 2'd0;
      b0  = CHAR_PCT;
      b1  = CHAR_PCT;
      b2  = CHAR_PCT;
      ph  = PH_IDLE;
      hd  = held;

      // Main step: bytes emitted by this input
      case (phase)
         PH_PCT: begin
            if (c_hex) begin
               ph = PH_DIGIT;
               hd = in_char;
            end else if (c_pct) begin
               cnt = 2'd1;
               ph  = PH_PCT;
            end else begin
               b1  = c_plain;
               cnt = 2'd2;
            end
         end
         PH_DIGIT: begin
            hd = 8'h00;
            if (c_hex) begin
               b0  = {hex_val(held), hex_val(in_char)};
               cnt = 2'd1;
            end else if (c_pct) begin
               b1  = held;
               cnt = 2'd2;
               ph  = PH_PCT;
            end else begin
               b1  = held;
               b2  = c_plain;
               cnt = 2'd3;
            end
         end
         default: begin
            // idle, and the unused code
            if (c_pct) begin
               ph = PH_PCT;
            end else begin
               b0  = c_plain;
               cnt = 2'd1;
            end
         end
      endcase

      // End of string: flush a cut escape literally
      if (in_final) begin
         if (ph == PH_PCT) begin
            // pending '%' lands at the next free slot; its value is already '%'
            cnt = cnt + 2'd1;
         end else if (ph == PH_DIGIT) begin
            // only reachable from PH_PCT with no bytes yet
            b1  = hd;
            cnt = 2'd2;
         end
         ph = PH_IDLE;
         hd = 8'h00;
      end
   end

   assign run.count  = cnt;
   assign run.bytes  = {b2, b1, b0};
   assign run.fin    = in_final;
   assign phase_next = ph;
   assign held_next  = hd;

endmodule

/* hw/rtl/pud_emit.sv */
// Result buffer: holds one decoded run and sends its bytes one per cycle while rsp_ready is high.
module pud_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  pud_pkg::run_type run_load,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_string_end
);
   import pud_pkg::*;

   logic       valid_ff;
   run_type    run_ff;
   logic [1:0] idx_ff;
   logic       last;
   logic       fire;

   assign last = (idx_ff == (run_ff.count - 2'd1));
   assign fire = valid_ff && rsp_ready;
   assign free = !valid_ff || (fire && last);

   // Buffer control and byte index
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (fire) begin
         if (last) begin
            valid_ff <= 1'b0;
            idx_ff   <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run_load;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_out_char = run_ff.bytes[0];
         2'd1:    rsp_out_char = run_ff.bytes[1];
         default: rsp_out_char = run_ff.bytes[2];
      endcase
   end

   assign rsp_valid      = valid_ff;
   assign rsp_run_last   = last;
   assign rsp_string_end = last && run_ff.fin;

endmodule

/* hw/rtl/percent_url_decoder_unit.sv */
// Top level of the percent/URL decoder: input register, escape state and result buffer.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one encoded byte per
//   transaction, req_in_final set on the last byte of a string.
//   Response channel (rsp_valid/rsp_ready) carries decoded bytes; each
//   request yields zero to three responses, rsp_run_last marks the last
//   response of a request and rsp_string_end the last byte of a string.
//   A request always yields at least one response when req_in_final is set.
// Timing:
//   A byte taken into the input register is decoded combinationally there;
//   its run is then registered in the result buffer, which offers the first
//   response. One request per cycle is taken while each yields at most one
//   byte and the receiver takes every response; a run of two or three bytes
//   holds the single result buffer until all of its bytes are taken.
// Reset clears the escape state (no '%' pending) and empties both stages.
// While the receiver stalls, the result buffer holds its run and one more
// request waits in the input register; req_ready drops after that.
module percent_url_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_char,
   input  logic       req_in_final,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import pud_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_final_ff;
   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] held_ff;
   logic [7:0] held_in;
   run_type    dec_run;
   logic       emit_free;
   logic       advance;
   logic       load;

   // Decode of the registered byte
   pud_decode u_decode (
      .phase      (phase_ff),
      .held       (held_ff),
      .in_char    (in_char_ff),
      .in_final   (in_final_ff),
      .run        (dec_run),
      .phase_next (phase_in),
      .held_next  (held_in)
   );

   // Consume the registered byte when its run fits in the buffer
   assign advance   = in_valid_ff && ((dec_run.count == 2'd0) || emit_free);
   assign load      = advance && (dec_run.count != 2'd0);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff  <= req_in_char;
         in_final_ff <= req_in_final;
      end
   end

   // Escape state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= 8'h00;
      end else if (advance) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   pud_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .run_load       (dec_run),
      .free           (emit_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

`ifndef SYNTHESIS
   // A final byte always leaves the decoder idle
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      advance && in_final_ff |=> phase_ff == PH_IDLE)
      else $error("escape state not idle after end of string");

   // A final byte always produces output
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      advance && in_final_ff |-> dec_run.count != 2'd0)
      else $error("end of string produced no byte");

   // Held digit is clear unless a digit is pending
   a_held_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_DIGIT |-> held_ff == 8'h00)
      else $error("stale held digit");

   // String end only on the last byte of a run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end before run end");
`endif

endmodule

/* verif/tb_percent_url_decoder_unit.sv */
// Self-checking testbench for the percent/URL decoder unit.
`timescale 1ns / 1ps

module tb_percent_url_decoder_unit;
   import pud_pkg::*;

   localparam int ITEM_TARGET = 320;
   localparam int REPORT_MAX  = 10;

   // One decoded byte as seen on the response channel
   typedef struct packed {
      logic [7:0] ch;
      logic       run_last;
      logic       string_end;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_char = 8'h00;
   logic       req_in_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;
   logic       rsp_string_end;

   // Decoder state mirror and pending decoded bytes
   phase_type   esc_phase = PH_IDLE;
   logic [7:0]  held_digit = 8'h00;
   logic [7:0]  run_bytes[$];
   decoded_type expected_q[$];

   int fail_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int string_count = 0;
   int escape_count = 0;

   // Sender burst shaping
   bit sender_gaps_on = 1'b1;
   int burst_left = 0;

   // Long receiver hold-off requests, served by the receiver process
   int hold_requests = 0;
   int holds_served = 0;

   always #2 clock = ~clock;

   percent_url_decoder_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_char    (req_in_char),
      .req_in_final   (req_in_final),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   // Hex digit value, or -1 when the byte is not a hex digit
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) return 8'(int'("0") + v);
      if (v < 16) return 8'(int'("a") + v - 10);
      return 8'(int'("A") + v - 16);
   endfunction

   // Handle a byte as if no escape were pending
   task automatic decode_fresh(input logic [7:0] c);
      esc_phase = PH_IDLE;
      if (c == CHAR_PCT) begin
         esc_phase = PH_PCT;
      end else if (c == CHAR_PLUS) begin
         run_bytes.insert(run_bytes.size(), CHAR_SPACE);
      end else begin
         run_bytes.insert(run_bytes.size(), c);
      end
   endtask

   // Work out the decoded run for one accepted byte
   task automatic predict_decode(input logic [7:0] c, input logic fin);
      int hi;
      int lo;
      bit last;
      decoded_type entry;
      run_bytes.delete();
      case (esc_phase)
         PH_PCT: begin
            if (nibble_of(c) >= 0) begin
               esc_phase = PH_DIGIT;
               held_digit = c;
            end else begin
               run_bytes.insert(run_bytes.size(), CHAR_PCT);
               decode_fresh(c);
            end
         end
         PH_DIGIT: begin
            lo = nibble_of(c);
            if (lo >= 0) begin
               hi = nibble_of(held_digit);
               if (hi < 0) hi = 0;
               run_bytes.insert(run_bytes.size(), {hi[3:0], lo[3:0]});
               esc_phase = PH_IDLE;
               escape_count++;
            end else begin
               run_bytes.insert(run_bytes.size(), CHAR_PCT);
               run_bytes.insert(run_bytes.size(), held_digit);
               decode_fresh(c);
            end
            held_digit = 8'h00;
         end
         default: begin
            decode_fresh(c);
         end
      endcase
      // End of string flushes any escape left open
      if (fin) begin
         if (esc_phase == PH_PCT) begin
            run_bytes.insert(run_bytes.size(), CHAR_PCT);
         end else if (esc_phase == PH_DIGIT) begin
            run_bytes.insert(run_bytes.size(), CHAR_PCT);
            run_bytes.insert(run_bytes.size(), held_digit);
         end
         esc_phase = PH_IDLE;
         held_digit = 8'h00;
         string_count++;
      end
      foreach (run_bytes[k]) begin
         last = (k == run_bytes.size() - 1);
         entry.ch = run_bytes[k];
         entry.run_last = last;
         entry.string_end = last && fin;
         expected_q.insert(expected_q.size(), entry);
      end
   endtask

   task automatic note_failure(input string what, input decoded_type want,
                               input decoded_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX) begin
         $display("[%0t] %s: expected char=%02h run_last=%b string_end=%b,",
                  $realtime, what, want.ch, want.run_last, want.string_end,
                  " got char=%02h run_last=%b string_end=%b",
                  got.ch, got.run_last, got.string_end);
      end
   endtask

   // Check each response transaction, then predict from each request transaction
   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_char, rsp_run_last, rsp_string_end};
            if (expected_q.size() == 0) begin
               note_failure("unexpected response", '0, got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) note_failure("response mismatch", want, got);
               checked_count++;
            end
         end
         if (req_valid && req_ready) begin
            predict_decode(req_in_char, req_in_final);
         end
      end
   end

   // Receiver stall pattern, with an occasional long hold-off on request
   always @(posedge clock) begin
      int mode;
      int mode_left;
      int hold_left;
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = $urandom_range(60, 90);
      end
      if (mode_left <= 0) begin
         mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Offer one byte and wait until it is taken
   task automatic send_byte(input logic [7:0] c, input logic fin);
      int gap;
      if (sender_gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_in_char <= c;
      req_in_final <= fin;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Send a whole string, final flag on its last byte
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], i == s.len() - 1);
      end
   endtask

   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_PLUS, 1'b0);
      send_byte("z", 1'b1);
   endtask

   // Well-formed escapes, upper and lower case, last digit with the final flag
   task automatic test_escapes();
      send_text("%41%fA");
   endtask

   // Bad first digit (plain, '%', '+') and bad second digit (plain, '+')
   task automatic test_bad_digits();
      send_text("%G%%+%Bx%0+");
   endtask

   // Escapes cut short by the end of the string
   task automatic test_cut_escapes();
      send_text("%");
      send_text("a%c");
   endtask

   // Receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      sender_gaps_on = 1'b0;
      hold_requests++;
      send_text("%41%42+x%7e%20ab%2B%2b%3D%3dend");
      sender_gaps_on = 1'b1;
   endtask

   // Random strings mixing well-formed escapes, '+', lone '%', bare hex digits and random bytes
   task automatic test_random_strings();
      logic [7:0] text[$];
      int len;
      int pick;
      while (sent_count < ITEM_TARGET) begin
         text.delete();
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               text.insert(text.size(), CHAR_PCT);
               text.insert(text.size(), random_hex_char());
               text.insert(text.size(), random_hex_char());
            end else if (pick < 45) begin
               text.insert(text.size(), CHAR_PLUS);
            end else if (pick < 55) begin
               text.insert(text.size(), CHAR_PCT);
            end else if (pick < 65) begin
               text.insert(text.size(), random_hex_char());
            end else begin
               text.insert(text.size(), 8'($urandom_range(0, 255)));
            end
         end
         foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_plain_bytes();
      test_escapes();
      test_bad_digits();
      test_cut_escapes();
      test_backpressure();
      test_random_strings();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Sent %0d bytes in %0d strings; checked %0d decoded bytes, %0d escapes decoded.",
               sent_count, string_count, checked_count, escape_count);
      $display("Random idling on both sides plus one long receiver hold-off; %0d failures.",
               fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/pud_pkg.sv
hw/rtl/pud_decode.sv
hw/rtl/pud_emit.sv
hw/rtl/percent_url_decoder_unit.sv
verif/tb_percent_url_decoder_unit.sv
